// File: sv/hdlcd_pkg.sv
`timescale 1ns / 1ps

package hdlcd_pkg;

    localparam logic [7:0]  FLAG_BYTE      = 8'h7E;
    localparam logic [7:0]  ESC_BYTE       = 8'h7D;
    localparam logic [7:0]  ESC_MASK       = 8'h20;
    localparam logic [7:0]  BROADCAST_ADDR = 8'hFF;
    localparam logic [15:0] MIN_LEN        = 16'd4;
    localparam logic [15:0] CRC_POLY       = 16'h8408;

    localparam logic [7:0]  OWN_ADDR_RST   = 8'd1;
    localparam logic [7:0]  PEER_ADDR_RST  = 8'd2;
    localparam logic [15:0] CRC_START_RST  = 16'hFFFF;
    localparam logic [15:0] CAPACITY_RST   = 16'd256;

    localparam logic [1:0]  REG_OWN_ADDR   = 2'd0;
    localparam logic [1:0]  REG_PEER_ADDR  = 2'd1;
    localparam logic [1:0]  REG_CRC_START  = 2'd2;
    localparam logic [1:0]  REG_CAPACITY   = 2'd3;

    typedef enum logic [1:0] {
        ST_HUNT = 2'd0,
        ST_ADDR = 2'd1,
        ST_DATA = 2'd2,
        ST_ESC  = 2'd3
    } line_state_t;

    typedef enum logic [2:0] {
        KIND_BYTE   = 3'd0,
        KIND_GOOD   = 3'd1,
        KIND_CRCERR = 3'd2,
        KIND_SHORT  = 3'd3,
        KIND_ABORT  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0]  own_address;
        logic [7:0]  partner_address;
        logic [15:0] crc_start;
        logic [15:0] frame_capacity;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [15:0] frame_length;
    } result_t;

    // reflected CRC-16, one byte
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: sv/hdlc_async_deframer_unit.sv
`timescale 1ns / 1ps
// Throughput: one line byte per cycle while the skid entry is empty; the per-byte
// CRC step and frame logic sit between the state registers and a two-entry output
// buffer (head and skid entries), where each result is registered before output.
// Reset (rst_n, async, active low): registers take their default values, the
// deframer hunts for a flag, and the output buffer is empty.

module hdlc_async_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  line_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  value,
    output logic [15:0] frame_length
);

    hdlcd_pkg::cfg_t    cfg_reg;
    hdlcd_pkg::result_t res;
    hdlcd_pkg::result_t head_reg, head_next;
    hdlcd_pkg::result_t skid_reg, skid_next;
    logic               head_valid_reg, head_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    logic               res_valid;
    logic               fire;
    logic               push;
    logic               pop;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address     <= hdlcd_pkg::OWN_ADDR_RST;
            cfg_reg.partner_address <= hdlcd_pkg::PEER_ADDR_RST;
            cfg_reg.crc_start       <= hdlcd_pkg::CRC_START_RST;
            cfg_reg.frame_capacity  <= hdlcd_pkg::CAPACITY_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                hdlcd_pkg::REG_OWN_ADDR:  cfg_reg.own_address     <= pwdata[7:0];
                hdlcd_pkg::REG_PEER_ADDR: cfg_reg.partner_address <= pwdata[7:0];
                hdlcd_pkg::REG_CRC_START: cfg_reg.crc_start       <= pwdata[15:0];
                hdlcd_pkg::REG_CAPACITY:  cfg_reg.frame_capacity  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            hdlcd_pkg::REG_OWN_ADDR:  prdata = {24'd0, cfg_reg.own_address};
            hdlcd_pkg::REG_PEER_ADDR: prdata = {24'd0, cfg_reg.partner_address};
            hdlcd_pkg::REG_CRC_START: prdata = {16'd0, cfg_reg.crc_start};
            hdlcd_pkg::REG_CAPACITY:  prdata = {16'd0, cfg_reg.frame_capacity};
            default:                  prdata = '0;
        endcase
    end

    assign in_ready = !skid_valid_reg;
    assign fire     = in_valid && in_ready;

    hdlcd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fire      (fire),
        .line_byte (line_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    assign push = fire && res_valid;
    assign pop  = head_valid_reg && out_ready;

    always_comb
    begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!head_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                // skid full means no push this cycle
                head_next       = skid_reg;
                head_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_next       = res;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            // head stalled: hold the new beat in the skid stage
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = head_valid_reg;
    assign kind         = head_reg.kind;
    assign value        = head_reg.value;
    assign frame_length = head_reg.frame_length;

endmodule

// File: sv/hdlcd_core.sv
`timescale 1ns / 1ps

module hdlcd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  hdlcd_pkg::cfg_t     cfg,
    input  logic                fire,
    input  logic [7:0]          line_byte,
    output logic                res_valid,
    output hdlcd_pkg::result_t  res
);

    hdlcd_pkg::line_state_t state_reg, state_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;

    logic [7:0]  b;
    logic [15:0] fcs;
    logic        addr_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hdlcd_pkg::ST_HUNT;
            count_reg <= '0;
            crc_reg   <= hdlcd_pkg::CRC_START_RST;
            held0_reg <= '0;
            held1_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        res_valid  = 1'b0;
        res.kind   = hdlcd_pkg::KIND_BYTE;
        res.value  = '0;
        res.frame_length = '0;

        b       = (state_reg == hdlcd_pkg::ST_ESC) ? (line_byte ^ hdlcd_pkg::ESC_MASK)
                                                   : line_byte;
        fcs     = {held1_reg, held0_reg};
        addr_ok = (b == cfg.own_address) || (b == cfg.partner_address)
               || (b == hdlcd_pkg::BROADCAST_ADDR);

        if (line_byte == hdlcd_pkg::FLAG_BYTE)
        begin
            if (state_reg != hdlcd_pkg::ST_HUNT && count_reg != '0)
            begin
                res_valid = 1'b1;
                res.frame_length = (count_reg >= 16'd2) ? count_reg - 16'd2 : '0;
                if (count_reg < hdlcd_pkg::MIN_LEN)
                    res.kind = hdlcd_pkg::KIND_SHORT;
                else if (crc_reg == fcs)
                    res.kind = hdlcd_pkg::KIND_GOOD;
                else
                    res.kind = hdlcd_pkg::KIND_CRCERR;
            end
            state_next = hdlcd_pkg::ST_ADDR;
            count_next = '0;
            crc_next   = cfg.crc_start;
            held0_next = '0;
            held1_next = '0;
        end
        else if (state_reg == hdlcd_pkg::ST_HUNT)
        begin
            state_next = hdlcd_pkg::ST_HUNT;
        end
        else if (line_byte == hdlcd_pkg::ESC_BYTE)
        begin
            state_next = hdlcd_pkg::ST_ESC;
        end
        else if (count_reg >= cfg.frame_capacity)
        begin
            // overflow: drop the byte and go hunting
            res_valid  = 1'b1;
            res.kind   = hdlcd_pkg::KIND_ABORT;
            state_next = hdlcd_pkg::ST_HUNT;
            count_next = '0;
            crc_next   = cfg.crc_start;
            held0_next = '0;
            held1_next = '0;
        end
        else
        begin
            if (count_reg >= 16'd2)
            begin
                crc_next  = hdlcd_pkg::crc_update(crc_reg, held0_reg);
                res_valid = 1'b1;
                res.kind  = hdlcd_pkg::KIND_BYTE;
                res.value = held0_reg;
            end
            held0_next = held1_reg;
            held1_next = b;
            count_next = count_reg + 16'd1;
            if (count_reg == '0)
            begin
                if (addr_ok)
                    state_next = hdlcd_pkg::ST_DATA;
                else
                begin
                    state_next = hdlcd_pkg::ST_HUNT;
                    count_next = '0;
                    crc_next   = cfg.crc_start;
                    held0_next = '0;
                    held1_next = '0;
                end
            end
            else
            begin
                state_next = hdlcd_pkg::ST_DATA;
            end
        end
    end

endmodule
